// ----- rtl/core/part_pkg.sv -----
// Shared types and constants for the point axis rotate/translate block.
// Request/result structs, opcodes, CORDIC arctangent table and gain.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package part_pkg;

  // Operation codes carried in each request
  typedef enum logic [1:0] {
    OP_ROT_X = 2'd0,
    OP_ROT_Y = 2'd1,
    OP_ROT_Z = 2'd2,
    OP_MOVE  = 2'd3
  } opcode_t;

  // One input request
  typedef struct packed {
    opcode_t            opcode;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [15:0]        turn_angle;
  } in_req_t;

  // One result
  typedef struct packed {
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic signed [31:0] result_z;
  } out_res_t;

  // Data that rides alongside the sine/cosine pipeline.
  // rel_a/rel_b: the two relative coordinates in the rotation plane.
  typedef struct packed {
    opcode_t            opcode;
    logic signed [32:0] rel_a;
    logic signed [32:0] rel_b;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
  } side_t;

  // CORDIC datapath width (x/y in Q2.30 with headroom, z as binary angle)
  localparam int CORDIC_W = 34;

  // Gain-compensated start value, 0.6072529350 in Q2.30
  localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 34'sd652032874;

  // Unit value in Q2.30
  localparam logic signed [CORDIC_W-1:0] ONE_Q30 = 34'sd1073741824;

  // Arctangent of 2^-i as a 32-bit binary angle
  localparam int ARC_ENTRIES = 24;
  localparam logic [31:0] ARC_TABLE [ARC_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

`default_nettype wire

// ----- rtl/core/part_cordic.sv -----
// Pipelined CORDIC sine/cosine with quadrant fold-out, one stage per rotation.
// Input: 16-bit binary angle. Output: clamped Q2.30 cosine and sine.
// Depends on part_pkg.
`timescale 1ns / 1ps
`default_nettype none

module part_cordic #(
  parameter int STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [15:0]        in_angle,
  output logic               out_valid,
  output logic signed [31:0] out_cos,
  output logic signed [31:0] out_sin
);

  localparam int W = part_pkg::CORDIC_W;

  logic                v_r    [STAGES];
  logic [1:0]          quad_r [STAGES];
  logic signed [W-1:0] x_r    [STAGES];
  logic signed [W-1:0] y_r    [STAGES];
  logic signed [W-1:0] z_r    [STAGES];

  // Micro-rotation stages
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic                v_in;
    logic [1:0]          q_in;
    logic signed [W-1:0] x_in;
    logic signed [W-1:0] y_in;
    logic signed [W-1:0] z_in;
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic signed [W-1:0] arc;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign q_in = in_angle[15:14];
      assign x_in = part_pkg::GAIN_Q30;
      assign y_in = '0;
      assign z_in = $signed({{(W-30){1'b0}}, in_angle[13:0], 16'b0});
    end else begin : g_next
      assign v_in = v_r[i-1];
      assign q_in = quad_r[i-1];
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign z_in = z_r[i-1];
    end

    assign dx  = y_in >>> i;
    assign dy  = x_in >>> i;
    assign arc = $signed({{(W-32){1'b0}}, part_pkg::ARC_TABLE[i]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_in;
      end
      quad_r[i] <= q_in;
      // rotate toward zero residual angle
      if (!z_in[W-1]) begin
        x_r[i] <= x_in - dx;
        y_r[i] <= y_in + dy;
        z_r[i] <= z_in - arc;
      end else begin
        x_r[i] <= x_in + dx;
        y_r[i] <= y_in - dy;
        z_r[i] <= z_in + arc;
      end
    end
  end

  // Clamp to unit range
  logic signed [31:0] xc;
  logic signed [31:0] yc;
  logic signed [31:0] cos_nxt;
  logic signed [31:0] sin_nxt;

  always_comb begin
    if (x_r[STAGES-1] > part_pkg::ONE_Q30) begin
      xc = part_pkg::ONE_Q30[31:0];
    end else if (x_r[STAGES-1] < -part_pkg::ONE_Q30) begin
      xc = -part_pkg::ONE_Q30[31:0];
    end else begin
      xc = x_r[STAGES-1][31:0];
    end
    if (y_r[STAGES-1] > part_pkg::ONE_Q30) begin
      yc = part_pkg::ONE_Q30[31:0];
    end else if (y_r[STAGES-1] < -part_pkg::ONE_Q30) begin
      yc = -part_pkg::ONE_Q30[31:0];
    end else begin
      yc = y_r[STAGES-1][31:0];
    end
  end

  // Quadrant fold-out
  always_comb begin
    unique case (quad_r[STAGES-1])
      2'd0: begin
        cos_nxt = xc;
        sin_nxt = yc;
      end
      2'd1: begin
        cos_nxt = -yc;
        sin_nxt = xc;
      end
      2'd2: begin
        cos_nxt = -xc;
        sin_nxt = -yc;
      end
      default: begin
        cos_nxt = yc;
        sin_nxt = -xc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v_r[STAGES-1];
    end
    out_cos <= cos_nxt;
    out_sin <= sin_nxt;
  end

  // Checks
  localparam logic signed [31:0] UNIT = 32'sd1073741824;

  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cos <= UNIT && out_cos >= -UNIT))
    else $error("cosine outside unit range");

  a_sin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sin <= UNIT && out_sin >= -UNIT))
    else $error("sine outside unit range");

  a_valid_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_valid, STAGES + 1))
    else $error("sine/cosine valid without a request");

endmodule

`default_nettype wire

// ----- rtl/core/part_mix.sv -----
// Rotation mixer: four products, rounded sums, center add-back and saturation.
// Three register stages: multiply, sum and round, add and saturate.
// Depends on part_pkg.
`timescale 1ns / 1ps
`default_nettype none

module part_mix (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  part_pkg::side_t      in_side,
  input  logic signed [31:0]   in_cos,
  input  logic signed [31:0]   in_sin,
  output logic                 out_valid,
  output part_pkg::out_res_t   out_res
);

  localparam logic signed [65:0] RND = 66'sd536870912;

  // Stage 1: products
  logic                 m_valid_r;
  part_pkg::side_t      m_side_r;
  logic signed [64:0]   ac_r;
  logic signed [64:0]   bs_r;
  logic signed [64:0]   as_r;
  logic signed [64:0]   bc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= in_valid;
    end
    m_side_r <= in_side;
    ac_r     <= in_side.rel_a * in_cos;
    bs_r     <= in_side.rel_b * in_sin;
    as_r     <= in_side.rel_a * in_sin;
    bc_r     <= in_side.rel_b * in_cos;
  end

  // Stage 2: u = a*c - b*s, v = a*s + b*c, rounded half up to Q16.16
  logic signed [65:0]   u_sum;
  logic signed [65:0]   v_sum;
  logic                 s_valid_r;
  part_pkg::side_t      s_side_r;
  logic signed [35:0]   u_r;
  logic signed [35:0]   v_r;

  always_comb begin
    u_sum = $signed({ac_r[64], ac_r}) - $signed({bs_r[64], bs_r}) + RND;
    v_sum = $signed({as_r[64], as_r}) + $signed({bc_r[64], bc_r}) + RND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= m_valid_r;
    end
    s_side_r <= m_side_r;
    u_r      <= u_sum[65:30];
    v_r      <= v_sum[65:30];
  end

  // Stage 3: pick base and offset per axis, add, saturate
  function automatic logic signed [36:0] ext32(input logic signed [31:0] v);
    ext32 = {{5{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic hi_ok;
    hi_ok = (v[36:31] == 6'b000000) || (v[36:31] == 6'b111111);
    if (hi_ok) begin
      sat32 = v[31:0];
    end else if (v[36]) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = 32'sh7FFFFFFF;
    end
  endfunction

  logic signed [36:0]  u_ext;
  logic signed [36:0]  v_ext;
  logic signed [36:0]  bx;
  logic signed [36:0]  by;
  logic signed [36:0]  bz;
  logic signed [36:0]  ox;
  logic signed [36:0]  oy;
  logic signed [36:0]  oz;
  part_pkg::out_res_t  res_nxt;

  always_comb begin
    u_ext = {u_r[35], u_r};
    v_ext = {v_r[35], v_r};
    bx = ext32(s_side_r.point_x);
    by = ext32(s_side_r.point_y);
    bz = ext32(s_side_r.point_z);
    ox = ext32(s_side_r.center_x);
    oy = ext32(s_side_r.center_y);
    oz = ext32(s_side_r.center_z);
    unique case (s_side_r.opcode)
      part_pkg::OP_ROT_X: begin
        ox = '0;
        by = u_ext;
        bz = v_ext;
      end
      part_pkg::OP_ROT_Y: begin
        bx = v_ext;
        oy = '0;
        bz = u_ext;
      end
      part_pkg::OP_ROT_Z: begin
        bx = u_ext;
        by = v_ext;
        oz = '0;
      end
      default: begin
        // translate: point plus vector
      end
    endcase
    res_nxt.result_x = sat32(bx + ox);
    res_nxt.result_y = sat32(by + oy);
    res_nxt.result_z = sat32(bz + oz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s_valid_r;
    end
    out_res <= res_nxt;
  end

  // Checks
  a_mix_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> ##3 out_valid)
    else $error("mixer dropped a request");

  a_mix_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_valid, 3))
    else $error("mixer result without a request");

  a_move_x: assert property (@(posedge clk) disable iff (!rst_n)
    (s_valid_r && s_side_r.opcode == part_pkg::OP_MOVE &&
     s_side_r.point_x == 32'sd0)
    |=> out_res.result_x == $past(s_side_r.center_x))
    else $error("translate of zero x lost the vector");

endmodule

`default_nettype wire

// ----- rtl/core/point_axis_rotate_translate_top.sv -----
// Top level of the point axis rotate/translate block.
// Instantiates part_cordic and part_mix; depends on part_pkg.
//
// Usage:
//   A request is taken on each rising edge where start is high and busy is
//   low. busy is always low: the pipeline takes one request every cycle.
//   Each request carries an opcode (rotate about x, y or z through a center,
//   or translate by a vector), a Q16.16 point, a Q16.16 center/vector and a
//   16-bit angle (65536 is a full turn).
//   Exactly one result leaves per request, in request order, on out_res for
//   one cycle with out_valid high.
//   The path runs through one input register, one stage per CORDIC
//   micro-rotation, one quadrant stage, then multiply, round and saturate
//   stages. Throughput is one request per cycle; the CORDIC stage chain
//   sets the depth.
//   The receiver cannot stall, so results are never held.
//   Synchronous reset clears all valid bits; requests in flight are dropped.
`timescale 1ns / 1ps
`default_nettype none

module point_axis_rotate_translate_top #(
  parameter int ROTATION_STAGES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  part_pkg::in_req_t   in_req,
  output logic                out_valid,
  output part_pkg::out_res_t  out_res
);

  localparam int NS = (ROTATION_STAGES < part_pkg::ARC_ENTRIES) ?
                      ROTATION_STAGES : part_pkg::ARC_ENTRIES;
  localparam int LATENCY = NS + 5;

  logic in_fire;

  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  // Relative coordinates in the rotation plane
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [32:0] dz;
  part_pkg::side_t    side_nxt;

  always_comb begin
    dx = $signed({in_req.point_x[31], in_req.point_x}) -
         $signed({in_req.center_x[31], in_req.center_x});
    dy = $signed({in_req.point_y[31], in_req.point_y}) -
         $signed({in_req.center_y[31], in_req.center_y});
    dz = $signed({in_req.point_z[31], in_req.point_z}) -
         $signed({in_req.center_z[31], in_req.center_z});
    side_nxt.opcode   = in_req.opcode;
    side_nxt.point_x  = in_req.point_x;
    side_nxt.point_y  = in_req.point_y;
    side_nxt.point_z  = in_req.point_z;
    side_nxt.center_x = in_req.center_x;
    side_nxt.center_y = in_req.center_y;
    side_nxt.center_z = in_req.center_z;
    unique case (in_req.opcode)
      part_pkg::OP_ROT_X: begin
        side_nxt.rel_a = dy;
        side_nxt.rel_b = dz;
      end
      part_pkg::OP_ROT_Y: begin
        side_nxt.rel_a = dz;
        side_nxt.rel_b = dx;
      end
      part_pkg::OP_ROT_Z: begin
        side_nxt.rel_a = dx;
        side_nxt.rel_b = dy;
      end
      default: begin
        side_nxt.rel_a = '0;
        side_nxt.rel_b = '0;
      end
    endcase
  end

  // Input register
  logic             ent_valid_r;
  logic [15:0]      ent_angle_r;
  part_pkg::side_t  ent_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
    end else begin
      ent_valid_r <= in_fire;
    end
    ent_angle_r <= in_req.turn_angle;
    ent_side_r  <= side_nxt;
  end

  // Sine/cosine pipeline
  logic               cs_valid;
  logic signed [31:0] cs_cos;
  logic signed [31:0] cs_sin;

  part_cordic #(
    .STAGES (NS)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ent_valid_r),
    .in_angle  (ent_angle_r),
    .out_valid (cs_valid),
    .out_cos   (cs_cos),
    .out_sin   (cs_sin)
  );

  // Side data delay line, matched to the CORDIC depth plus quadrant stage
  part_pkg::side_t side_dly_r [NS+1];

  always_ff @(posedge clk) begin
    side_dly_r[0] <= ent_side_r;
    for (int k = 1; k <= NS; k++) begin
      side_dly_r[k] <= side_dly_r[k-1];
    end
  end

  // Rotation mixer and output register
  part_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cs_valid),
    .in_side   (side_dly_r[NS]),
    .in_cos    (cs_cos),
    .in_sin    (cs_sin),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // Checks
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##LATENCY out_valid)
    else $error("request produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a request");

  a_axis_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_req.opcode == part_pkg::OP_ROT_Z)
    |-> ##LATENCY (out_res.result_z == $past(in_req.point_z, LATENCY)))
    else $error("rotation axis coordinate changed");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for point_axis_rotate_translate_top.
// Drives directed and random rotate/translate requests and checks every result
// against a typed expectation or a behavioral CORDIC/fixed-point predictor; depends on part_pkg.
`timescale 1ns / 1ps

module tb_top;

  localparam int STAGES       = 16;
  localparam int LATENCY      = (STAGES < 24 ? STAGES : 24) + 5;
  localparam int RANDOM_ITEMS = 750;
  localparam int QUIET_LIMIT  = 2000;

  localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] NEG1 = 32'hFFFF_FFFF;

  // CORDIC constants: gain-corrected start value and unit, both Q2.30
  localparam logic signed [63:0] START_GAIN = 64'sd652032874;
  localparam logic signed [63:0] UNIT_Q30   = 64'sd1073741824;
  localparam logic signed [63:0] HALF_Q30   = 64'sd536870912;
  localparam logic signed [63:0] SAT_HI     = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO     = -64'sd2147483648;

  // atan(2^-i) as 32-bit binary angles
  localparam logic signed [63:0] ATAN_BAM [24] = '{
    64'sh20000000, 64'sh12E4051E, 64'sh09FB385B, 64'sh051111D4,
    64'sh028B0D43, 64'sh0145D7E1, 64'sh00A2F61E, 64'sh00517C55,
    64'sh0028BE53, 64'sh00145F2F, 64'sh000A2F98, 64'sh000517CC,
    64'sh00028BE6, 64'sh000145F3, 64'sh0000A2FA, 64'sh0000517D,
    64'sh000028BE, 64'sh0000145F, 64'sh00000A30, 64'sh00000518,
    64'sh0000028C, 64'sh00000146, 64'sh000000A3, 64'sh00000051
  };

  typedef struct {
    part_pkg::in_req_t  req;
    logic               known;
    part_pkg::out_res_t res;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  part_pkg::in_req_t  in_req = '0;
  logic               out_valid;
  part_pkg::out_res_t out_res;

  // expectation that travels with the request when a row has a typed result
  logic               req_known = 1'b0;
  part_pkg::out_res_t req_result = '0;

  part_pkg::out_res_t pending_points [$];
  part_pkg::out_res_t oldest;
  stim_row_t          directed_rows [$];
  int                 mismatch_count = 0;
  int                 results_seen = 0;
  int                 quiet_cycles = 0;

  point_axis_rotate_translate_top #(.ROTATION_STAGES(STAGES)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Quadrant fold plus fixed-stage CORDIC, cosine and sine in Q2.30
  function automatic void cordic_sin_cos(input logic [15:0] angle,
                                         output logic signed [63:0] cos_q30,
                                         output logic signed [63:0] sin_q30);
    logic signed [63:0] x, y, z, dx, dy;
    int i;
    x = START_GAIN;
    y = '0;
    z = $signed({34'd0, angle[13:0], 16'd0});
    for (i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_BAM[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_BAM[i];
      end
    end
    if (x > UNIT_Q30) x = UNIT_Q30;
    else if (x < -UNIT_Q30) x = -UNIT_Q30;
    if (y > UNIT_Q30) y = UNIT_Q30;
    else if (y < -UNIT_Q30) y = -UNIT_Q30;
    case (angle[15:14])
      2'd0: begin cos_q30 = x;  sin_q30 = y;  end
      2'd1: begin cos_q30 = -y; sin_q30 = x;  end
      2'd2: begin cos_q30 = -x; sin_q30 = -y; end
      default: begin cos_q30 = y; sin_q30 = -x; end
    endcase
  endfunction

  // p*m + q*n rounded half up from Q16.16 x Q2.30 to Q16.16
  function automatic logic signed [63:0] round_mix(input logic signed [63:0] p, m, q, n);
    logic signed [63:0] acc;
    acc = p * m + q * n + HALF_Q30;
    return acc >>> 30;
  endfunction

  function automatic logic [31:0] clip32(input logic signed [63:0] v);
    if (v > SAT_HI) return MAXV;
    if (v < SAT_LO) return MINV;
    return v[31:0];
  endfunction

  // Expected output for one request
  function automatic part_pkg::out_res_t transform_point(input part_pkg::in_req_t req);
    logic signed [63:0] px, py, pz, cx, cy, cz, ax, ay, az, c, s;
    part_pkg::out_res_t r;
    px = $signed(req.point_x);
    py = $signed(req.point_y);
    pz = $signed(req.point_z);
    cx = $signed(req.center_x);
    cy = $signed(req.center_y);
    cz = $signed(req.center_z);
    ax = px - cx;
    ay = py - cy;
    az = pz - cz;
    cordic_sin_cos(req.turn_angle, c, s);
    case (req.opcode)
      part_pkg::OP_ROT_X: begin
        r.result_x = req.point_x;
        r.result_y = clip32(round_mix(ay, c, az, -s) + cy);
        r.result_z = clip32(round_mix(ay, s, az, c) + cz);
      end
      part_pkg::OP_ROT_Y: begin
        r.result_x = clip32(round_mix(az, s, ax, c) + cx);
        r.result_y = req.point_y;
        r.result_z = clip32(round_mix(az, c, ax, -s) + cz);
      end
      part_pkg::OP_ROT_Z: begin
        r.result_x = clip32(round_mix(ax, c, ay, -s) + cx);
        r.result_y = clip32(round_mix(ax, s, ay, c) + cy);
        r.result_z = req.point_z;
      end
      default: begin
        r.result_x = clip32(px + cx);
        r.result_y = clip32(py + cy);
        r.result_z = clip32(pz + cz);
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic part_pkg::in_req_t make_req(input part_pkg::opcode_t op,
                                                 input logic [31:0] px, py, pz,
                                                 input logic [31:0] cx, cy, cz,
                                                 input logic [15:0] angle);
    part_pkg::in_req_t r;
    r.opcode     = op;
    r.point_x    = px;
    r.point_y    = py;
    r.point_z    = pz;
    r.center_x   = cx;
    r.center_y   = cy;
    r.center_z   = cz;
    r.turn_angle = angle;
    return r;
  endfunction

  function automatic void add_row(input part_pkg::opcode_t op,
                                  input logic [31:0] px, py, pz, cx, cy, cz,
                                  input logic [15:0] angle, input logic known,
                                  input logic [31:0] rx, ry, rz);
    stim_row_t row;
    row.req          = make_req(op, px, py, pz, cx, cy, cz, angle);
    row.known        = known;
    row.res.result_x = rx;
    row.res.result_y = ry;
    row.res.result_z = rz;
    directed_rows.push_back(row);
  endfunction

  // Mostly modest coordinates, some full range, some extremes
  function automatic logic [31:0] random_coord();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    if (pick < 8) return $urandom;
    case ($urandom_range(0, 4))
      0: return MAXV;
      1: return MINV;
      2: return 32'h0;
      3: return NEG1;
      default: return 32'h1;
    endcase
  endfunction

  // Center close to the point now and then, so rotations stay in range
  function automatic logic [31:0] random_center(input logic [31:0] pt);
    if ($urandom_range(0, 2) == 0)
      return pt + ($urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
    return random_coord();
  endfunction

  // Random angle, biased toward quadrant edges
  function automatic logic [15:0] random_angle();
    logic [13:0] frac;
    if ($urandom_range(0, 4) < 3) return 16'($urandom_range(0, 16'hFFFF));
    case ($urandom_range(0, 3))
      0: frac = 14'h0000;
      1: frac = 14'h0001;
      2: frac = 14'h3FFF;
      default: frac = 14'h2000;
    endcase
    return {2'($urandom_range(0, 3)), frac};
  endfunction

  function automatic part_pkg::in_req_t random_request();
    logic [31:0] px, py, pz;
    px = random_coord();
    py = random_coord();
    pz = random_coord();
    return make_req(part_pkg::opcode_t'($urandom_range(0, 3)), px, py, pz,
                    random_center(px), random_center(py), random_center(pz),
                    random_angle());
  endfunction

  // Hold one request on the inputs until the block takes it
  task automatic send(input part_pkg::in_req_t req, input logic known,
                      input part_pkg::out_res_t res);
    start      <= 1'b1;
    in_req     <= req;
    req_known  <= known;
    req_result <= res;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch on result %0d: %s", $time, results_seen, msg);
    mismatch_count++;
  endtask

  task automatic compare_axis(input string axis, input logic [31:0] got, want);
    if (got !== want)
      report_mismatch($sformatf("result_%s got %h expected %h", axis, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: check results, record accepted requests, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_points.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        oldest = pending_points.pop_front();
        compare_axis("x", out_res.result_x, oldest.result_x);
        compare_axis("y", out_res.result_y, oldest.result_y);
        compare_axis("z", out_res.result_z, oldest.result_z);
      end
      results_seen++;
    end
    if (rst_n && start && !busy)
      pending_points.push_back(req_known ? req_result : transform_point(in_req));
    // watchdog on cycles where nothing moves
    if (!rst_n || out_valid || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no activity for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int sent;
    int burst;
    int k;

    // translate: plain sums, saturation both ways, angle ignored
    add_row(part_pkg::OP_MOVE, 0, 0, 0, 0, 0, 0, 16'h0000, 1'b1, 0, 0, 0);
    add_row(part_pkg::OP_MOVE, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 16'h0000,
            1'b1, MAXV, MAXV, MAXV);
    add_row(part_pkg::OP_MOVE, MINV, MINV, MINV, MINV, MINV, MINV, 16'h4000,
            1'b1, MINV, MINV, MINV);
    add_row(part_pkg::OP_MOVE, MAXV, MINV, MAXV, MINV, MAXV, MINV, 16'hFFFF,
            1'b1, NEG1, NEG1, NEG1);
    add_row(part_pkg::OP_MOVE, ONE, -ONE, 1, -ONE, ONE, NEG1, 16'h8000,
            1'b1, 0, 0, 0);
    // rotating the center itself returns it; axis coordinate passes through
    add_row(part_pkg::OP_ROT_X, MAXV, ONE, -ONE, MINV, ONE, -ONE, 16'h1234,
            1'b1, MAXV, ONE, -ONE);
    add_row(part_pkg::OP_ROT_Y, ONE, MINV, MAXV, ONE, MAXV, MAXV, 16'hABCD,
            1'b1, ONE, MINV, MAXV);
    add_row(part_pkg::OP_ROT_Z, MINV, MAXV, 7, MINV, MAXV, -7, 16'hFFFF,
            1'b1, MINV, MAXV, 7);
    // quadrant edges and general angles, predicted
    add_row(part_pkg::OP_ROT_X, 0, ONE, 0, 0, 0, 0, 16'h0000, 1'b0, 0, 0, 0);
    add_row(part_pkg::OP_ROT_X, 0, ONE, 0, 0, 0, 0, 16'h4000, 1'b0, 0, 0, 0);
    add_row(part_pkg::OP_ROT_Y, ONE, 0, ONE, 0, 0, 0, 16'h8000, 1'b0, 0, 0, 0);
    add_row(part_pkg::OP_ROT_Z, ONE, ONE, ONE, 0, 0, 0, 16'hC000, 1'b0, 0, 0, 0);
    add_row(part_pkg::OP_ROT_Z, ONE, ONE, ONE, 0, 0, 0, 16'h3FFF, 1'b0, 0, 0, 0);
    add_row(part_pkg::OP_ROT_X, 0, -ONE, 2 * ONE, 0, 0, 0, 16'hFFFF,
            1'b0, 0, 0, 0);
    add_row(part_pkg::OP_ROT_Y, 3 * ONE, 5, -ONE, ONE, 0, ONE, 16'h2000,
            1'b0, 0, 0, 0);
    // full-range relative vectors, saturating
    add_row(part_pkg::OP_ROT_Z, MAXV, MAXV, MINV, MINV, MINV, MAXV, 16'h0000,
            1'b0, 0, 0, 0);
    add_row(part_pkg::OP_ROT_Z, MAXV, MAXV, MINV, MINV, MINV, MAXV, 16'h8000,
            1'b0, 0, 0, 0);
    add_row(part_pkg::OP_ROT_X, MINV, MINV, MAXV, MAXV, MAXV, MINV, 16'h6000,
            1'b0, 0, 0, 0);
    add_row(part_pkg::OP_ROT_Y, MAXV, 0, MINV, MINV, 0, MAXV, 16'hE000,
            1'b0, 0, 0, 0);
    add_row(part_pkg::OP_ROT_X, 7, 32'h1234_5678, 32'h9ABC_DEF0, 0, 32'hFFFF_0000, ONE,
            16'h4001, 1'b0, 0, 0, 0);
    add_row(part_pkg::OP_ROT_Y, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h5555_5555,
            32'hAAAA_AAAA, 0, 32'h3333_3333, 16'hBFFF, 1'b0, 0, 0, 0);
    add_row(part_pkg::OP_ROT_Z, 32'hCCCC_CCCC, 32'h0000_8000, 0, 32'h0000_7FFF,
            NEG1, MAXV, 16'h7FFF, 1'b0, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (k = 0; k < directed_rows.size(); k++) begin
      send(directed_rows[k].req, directed_rows[k].known, directed_rows[k].res);
      if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 3));
    end

    // random bursts with random gaps; one full drain halfway through
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        send(random_request(), 1'b0, '0);
        sent++;
        if (sent == RANDOM_ITEMS / 2) begin
          start <= 1'b0;
          while (pending_points.size() != 0) @(negedge clk);
          @(posedge clk);
        end
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
    end

    // let the pipeline empty, then watch for stray results
    start <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
